// File: sv/gdf_pkg.sv
// shared types and constants for the gf(2) dependency finder
package gdf_pkg;

    localparam int WORD_W      = 64;
    localparam int IN_WORDS    = 6;
    localparam int PIVOT_BIT_W = 9;
    localparam int ITEM_POS_W  = 6;
    localparam int WEIGHT_W    = 6;
    localparam int MASK_OUT_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;
    localparam int EPOCH_W     = 8;

    localparam logic [ITEM_POS_W-1:0] ITEMS_SAT   = 6'd63;
    localparam logic [EPOCH_W-1:0]    EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0]    EPOCH_LAST  = 8'hff;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_CORE_WEIGHT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CORE_WEIGHT = 2'd1;

    typedef enum logic [2:0] {
        OUTCOME_INSERTED  = 3'd0,
        OUTCOME_DEPENDENT = 3'd1,
        OUTCOME_CORE      = 3'd2,
        OUTCOME_IGNORED   = 3'd3,
        OUTCOME_OVERFLOW  = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_APPLY,
        ST_WEIGH,
        ST_JUDGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   any;
        logic [PIVOT_BIT_W-1:0] index;
    } pivot_find_t;

endpackage

// File: sv/gdf_pivot_find.sv
// highest set bit search over the working vector
module gdf_pivot_find
    import gdf_pkg::*;
#(
    parameter int VEC_W = 384
) (
    input  logic [VEC_W-1:0] vec,
    output pivot_find_t      found
);

    localparam int WORDS  = (VEC_W + WORD_W - 1) / WORD_W;
    localparam int WSEL_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [WORDS*WORD_W-1:0] padded;
    logic [WORDS-1:0]        word_nz;
    logic [WSEL_W-1:0]       word_sel;
    logic [WORD_W-1:0]       word_val;
    logic [7:0]              oct_nz;
    logic [2:0]              oct_sel;
    logic [7:0]              oct_val;
    logic [2:0]              pos_sel;

    // word, then octet, then bit: three short priority picks
    always_comb begin
        padded   = (WORDS*WORD_W)'(vec);
        word_sel = '0;
        for (int w = 0; w < WORDS; w++) begin
            word_nz[w] = |padded[w*WORD_W +: WORD_W];
            if (word_nz[w]) begin
                word_sel = WSEL_W'(w);
            end
        end
        word_val = padded[word_sel*WORD_W +: WORD_W];

        oct_sel = '0;
        for (int o = 0; o < 8; o++) begin
            oct_nz[o] = |word_val[o*8 +: 8];
            if (oct_nz[o]) begin
                oct_sel = 3'(o);
            end
        end
        oct_val = word_val[oct_sel*8 +: 8];

        pos_sel = '0;
        for (int b = 0; b < 8; b++) begin
            if (oct_val[b]) begin
                pos_sel = 3'(b);
            end
        end

        found.any   = |word_nz;
        found.index = PIVOT_BIT_W'({word_sel, oct_sel, pos_sel});
    end

endmodule

// File: sv/gf2_dependency_finder.sv
// top level: gf(2) basis insertion with dependency tracking
//
// One vector is handled at a time. After acceptance the sequencer finds the
// vector's highest set bit, reads the basis entry at that pivot from the
// basis memory (separate read and write ports) and, if the entry belongs to
// the current set, XORs it in; each such reduction is a search and read in
// ST_FIND, then the XOR in ST_APPLY, and there are at most MAX_ITEMS - 1 of
// them. An inserted item then writes its entry in ST_APPLY; one that reduces
// to zero passes through ST_WEIGH and ST_JUDGE; ignored and overflow items go
// straight to ST_DONE, where a result still waiting in the output register
// holds the sequencer until that word is taken.
// Entries are tagged with a set epoch instead of per-entry valid bits, so
// starting a set costs nothing, except that after reset and on one set start
// in every 255 the memory is swept, one entry a cycle, over all
// min(PIVOT_COUNT, 64*WORD_COUNT) entries before the item is processed.
// The result sits in an output register, so the next word can be accepted
// while the previous result waits.
module gf2_dependency_finder
    import gdf_pkg::*;
#(
    parameter int PIVOT_COUNT = 384,
    parameter int WORD_COUNT  = 6,
    parameter int MAX_ITEMS   = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_start_set,
    input  logic [WORD_W-1:0]      s_vector_word0,
    input  logic [WORD_W-1:0]      s_vector_word1,
    input  logic [WORD_W-1:0]      s_vector_word2,
    input  logic [WORD_W-1:0]      s_vector_word3,
    input  logic [WORD_W-1:0]      s_vector_word4,
    input  logic [WORD_W-1:0]      s_vector_word5,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_outcome,
    output logic [ITEM_POS_W-1:0]  m_item_position,
    output logic [PIVOT_BIT_W-1:0] m_pivot_bit,
    output logic [MASK_OUT_W-1:0]  m_dependency_mask,
    output logic [WEIGHT_W-1:0]    m_dependency_weight,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int VEC_W  = (PIVOT_COUNT < WORD_COUNT*WORD_W) ? PIVOT_COUNT
                                                              : WORD_COUNT*WORD_W;
    localparam int ADDR_W = $clog2(VEC_W);
    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int MEM_W  = EPOCH_W + MAX_ITEMS + VEC_W;

    function automatic logic [WEIGHT_W-1:0] count_ones(input logic [MASK_OUT_W-1:0] m);
        logic [3:0]          part;
        logic [WEIGHT_W-1:0] total;
        total = '0;
        for (int o = 0; o < MASK_OUT_W/8; o++) begin
            part = '0;
            for (int i = 0; i < 8; i++) begin
                part = part + 4'(m[8*o+i]);
            end
            total = total + WEIGHT_W'(part);
        end
        return total;
    endfunction

    // control registers
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                   clr_item_reg, clr_item_next;
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [ITEM_POS_W-1:0]  items_seen_reg, items_seen_next;
    logic                   core_seen_reg, core_seen_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CFG_DATA_W-1:0]  min_reg, max_reg;

    // working registers
    logic [VEC_W-1:0]       v_reg, v_next;
    logic [MAX_ITEMS-1:0]   subset_reg, subset_next;
    logic [ITEM_POS_W-1:0]  pos_reg, pos_next;
    logic [PIVOT_BIT_W-1:0] pivot_reg, pivot_next;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;
    outcome_t               outcome_reg, outcome_next;

    // output registers
    outcome_t               m_outcome_reg;
    logic [ITEM_POS_W-1:0]  m_item_position_reg;
    logic [PIVOT_BIT_W-1:0] m_pivot_bit_reg;
    logic [MASK_OUT_W-1:0]  m_dependency_mask_reg;
    logic [WEIGHT_W-1:0]    m_dependency_weight_reg;
    logic                   out_load;

    // basis memory: {epoch tag, item mask, vector}
    logic [MEM_W-1:0]       basis_mem [VEC_W];
    logic [MEM_W-1:0]       rd_data_reg;
    logic                   mem_rd_en;
    logic [ADDR_W-1:0]      mem_rd_addr;
    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_wr_addr;
    logic [MEM_W-1:0]       mem_wr_data;

    logic [IN_WORDS*WORD_W-1:0] in_all;
    logic [VEC_W-1:0]           v_in;
    logic [ITEM_POS_W-1:0]      items_base;
    logic                       core_base;
    logic [EPOCH_W-1:0]         rd_tag;
    logic [MAX_ITEMS-1:0]       rd_mask;
    logic [VEC_W-1:0]           rd_vec;
    pivot_find_t                pf;

    assign in_all = {s_vector_word5, s_vector_word4, s_vector_word3,
                     s_vector_word2, s_vector_word1, s_vector_word0};
    assign v_in   = in_all[VEC_W-1:0];

    assign rd_vec  = rd_data_reg[VEC_W-1:0];
    assign rd_mask = rd_data_reg[VEC_W +: MAX_ITEMS];
    assign rd_tag  = rd_data_reg[VEC_W+MAX_ITEMS +: EPOCH_W];

    gdf_pivot_find #(
        .VEC_W (VEC_W)
    ) u_pivot_find (
        .vec   (v_reg),
        .found (pf)
    );

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_item_next   = clr_item_reg;
        epoch_next      = epoch_reg;
        items_seen_next = items_seen_reg;
        core_seen_next  = core_seen_reg;
        v_next          = v_reg;
        subset_next     = subset_reg;
        pos_next        = pos_reg;
        pivot_next      = pivot_reg;
        weight_next     = weight_reg;
        outcome_next    = outcome_reg;
        out_load        = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = pf.index[ADDR_W-1:0];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pivot_reg[ADDR_W-1:0];
        mem_wr_data     = {epoch_reg, subset_reg, v_reg};
        items_base      = s_start_set ? '0 : items_seen_reg;
        core_base       = s_start_set ? 1'b0 : core_seen_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                // tag 0 never matches a live epoch
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(VEC_W - 1)) begin
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_FIND : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    pos_next        = items_base;
                    items_seen_next = (items_base != ITEMS_SAT) ? items_base + 1'b1
                                                                : items_base;
                    core_seen_next  = core_base;
                    v_next          = v_in;
                    subset_next     = MAX_ITEMS'(1) << items_base[IDX_W-1:0];
                    pivot_next      = '0;
                    weight_next     = '0;
                    if (core_base) begin
                        outcome_next = OUTCOME_IGNORED;
                        state_next   = ST_DONE;
                    end else if (items_base >= ITEM_POS_W'(MAX_ITEMS)) begin
                        outcome_next = OUTCOME_OVERFLOW;
                        state_next   = ST_DONE;
                    end else if (s_start_set && epoch_reg == EPOCH_LAST) begin
                        epoch_next    = EPOCH_FIRST;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end else begin
                        if (s_start_set) begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND: begin
                if (pf.any) begin
                    mem_rd_en  = 1'b1;
                    pivot_next = pf.index;
                    state_next = ST_APPLY;
                end else begin
                    state_next = ST_WEIGH;
                end
            end
            ST_APPLY: begin
                if (rd_tag == epoch_reg) begin
                    v_next      = v_reg ^ rd_vec;
                    subset_next = subset_reg ^ rd_mask;
                    state_next  = ST_FIND;
                end else begin
                    mem_wr_en    = 1'b1;
                    outcome_next = OUTCOME_INSERTED;
                    state_next   = ST_DONE;
                end
            end
            ST_WEIGH: begin
                weight_next = count_ones(MASK_OUT_W'(subset_reg));
                state_next  = ST_JUDGE;
            end
            ST_JUDGE: begin
                if (weight_reg >= min_reg && weight_reg <= max_reg) begin
                    outcome_next   = OUTCOME_CORE;
                    core_seen_next = 1'b1;
                end else begin
                    outcome_next = OUTCOME_DEPENDENT;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_item_reg   <= 1'b0;
            epoch_reg      <= EPOCH_FIRST;
            items_seen_reg <= '0;
            core_seen_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_item_reg   <= clr_item_next;
            epoch_reg      <= epoch_next;
            items_seen_reg <= items_seen_next;
            core_seen_reg  <= core_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= 6'd8;
            max_reg <= 6'd18;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_CORE_WEIGHT: min_reg <= cfg_wdata;
                REG_MAX_CORE_WEIGHT: max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        v_reg       <= v_next;
        subset_reg  <= subset_next;
        pos_reg     <= pos_next;
        pivot_reg   <= pivot_next;
        weight_reg  <= weight_next;
        outcome_reg <= outcome_next;
    end

    // fields that do not apply to the outcome go out as zero
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_outcome_reg       <= outcome_reg;
            m_item_position_reg <= pos_reg;
            m_pivot_bit_reg     <= (outcome_reg == OUTCOME_INSERTED) ? pivot_reg : '0;
            if (outcome_reg == OUTCOME_DEPENDENT || outcome_reg == OUTCOME_CORE) begin
                m_dependency_mask_reg   <= MASK_OUT_W'(subset_reg);
                m_dependency_weight_reg <= weight_reg;
            end else begin
                m_dependency_mask_reg   <= '0;
                m_dependency_weight_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            basis_mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            rd_data_reg <= basis_mem[mem_rd_addr];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_outcome           = m_outcome_reg;
    assign m_item_position     = m_item_position_reg;
    assign m_pivot_bit         = m_pivot_bit_reg;
    assign m_dependency_mask   = m_dependency_mask_reg;
    assign m_dependency_weight = m_dependency_weight_reg;

`ifndef SYNTH
    a_weight_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_outcome == OUTCOME_DEPENDENT || m_outcome == OUTCOME_CORE))
        |-> (int'(m_dependency_weight) == $countones(m_dependency_mask)))
        else $error("dependency weight disagrees with mask");

    a_start_restarts_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_start_set) |=> (pos_reg == '0))
        else $error("set start did not restart item position");

    a_pivot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_outcome == OUTCOME_INSERTED)
        |-> (m_pivot_bit < PIVOT_BIT_W'(VEC_W)))
        else $error("pivot beyond vector width");
`endif

endmodule
